/* hdl/chtlp_pkg.sv */
// shared types and constants for the coordinate hash table
package chtlp_pkg;

    // fixed field widths
    localparam int TS_W     = 11;
    localparam int STATUS_W = 3;
    localparam int FH_W     = 16;
    localparam int SLOT_W   = 10;

    localparam logic [TS_W-1:0] TS_RESET = 11'd1024;

    // hash multipliers
    localparam logic [31:0] HASH_MUL_X = 32'd18937;
    localparam logic [31:0] HASH_MUL_Y = 32'd20483;
    localparam logic [31:0] HASH_MUL_Z = 32'd29303;

    // sequencing counts
    localparam int CNT_W     = 5;
    localparam int MUL_TERMS = 3;
    localparam int DIV_STEPS = 32;

    // result codes
    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status ST_FOUND     = 3'd0;
    localparam t_status ST_NOT_FOUND = 3'd1;
    localparam t_status ST_INSERTED  = 3'd2;
    localparam t_status ST_PRESENT   = 3'd3;
    localparam t_status ST_FULL      = 3'd4;

    // coordinate select for the shared multiplier
    typedef logic [1:0] t_mul_sel;
    localparam t_mul_sel SEL_X = 2'd0;
    localparam t_mul_sel SEL_Y = 2'd1;
    localparam t_mul_sel SEL_Z = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic     start;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     acc_en;
        logic     div_step;
        logic     home_load;
        logic     prb_rd;
        logic     prb_chk;
        logic     prb_adv;
        logic     clr_step;
        logic     out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic match;
        logic last;
        logic clr_last;
    } t_dp_sts;

endpackage

/* hdl/chtlp_ram.sv */
// generic simple dual-port ram with registered read
module chtlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/chtlp_dpath.sv */
// datapath: hash, modulo, probe address, slot store and result registers
module chtlp_dpath
    import chtlp_pkg::*;
#(
    parameter int CAPACITY    = 1024,
    parameter int COORD_BITS  = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts,
    input  logic                   i_cfg_we,
    input  logic [TS_W-1:0]        i_cfg_table_size,
    input  logic                   i_opcode,
    input  logic [COORD_BITS-1:0]  i_key_x,
    input  logic [COORD_BITS-1:0]  i_key_y,
    input  logic [COORD_BITS-1:0]  i_key_z,
    input  logic [HANDLE_BITS-1:0] i_entry_handle,
    output logic [STATUS_W-1:0]    o_status,
    output logic [FH_W-1:0]        o_found_handle,
    output logic [SLOT_W-1:0]      o_slot_index
);

    localparam int AW = $clog2(CAPACITY);
    localparam int SW = $clog2(CAPACITY + 1);
    localparam int CB = COORD_BITS;
    localparam int HB = HANDLE_BITS;
    localparam int RW = 1 + 3 * CB + HB;

    logic [TS_W-1:0] r_table_size;
    logic            r_op;
    logic [CB-1:0]   r_kx, r_ky, r_kz;
    logic [HB-1:0]   r_handle;
    logic [SW-1:0]   r_size;
    logic [31:0]     r_prod;
    logic [31:0]     r_acc;
    logic [SW-1:0]   r_rem;
    logic [AW-1:0]   r_cell;
    logic [AW-1:0]   r_home;
    logic [SW-1:0]   r_n;
    t_status         r_res_status;
    logic [FH_W-1:0] r_res_handle;
    logic [SLOT_W-1:0] r_res_slot;
    logic [STATUS_W-1:0] r_out_status;
    logic [FH_W-1:0]   r_out_handle;
    logic [SLOT_W-1:0] r_out_slot;

    logic [SW-1:0]   used_size;
    logic [31:0]     mul_coord;
    logic [31:0]     mul_const;
    logic [SW:0]     div_shift;
    logic [SW-1:0]   n_rem;
    logic [AW:0]     cell_inc;
    logic [AW-1:0]   n_cell_adv;
    logic            ram_we;
    logic [RW-1:0]   ram_wdata;
    logic [RW-1:0]   rdata;
    logic            rd_valid;
    logic [CB-1:0]   rd_kx, rd_ky, rd_kz;
    logic [HB-1:0]   rd_handle;
    logic            key_eq;
    t_status         n_res_status;

    // size in use, clamped to 1..CAPACITY
    always_comb begin
        priority if (r_table_size == '0) begin
            used_size = SW'(1);
        end else if (32'(r_table_size) > 32'(CAPACITY)) begin
            used_size = SW'(CAPACITY);
        end else begin
            used_size = SW'(r_table_size);
        end
    end

    // shared multiplier operand select
    always_comb begin
        unique case (i_cmd.mul_sel)
            SEL_Y: begin
                mul_coord = 32'($signed(r_ky));
                mul_const = HASH_MUL_Y;
            end
            SEL_Z: begin
                mul_coord = 32'($signed(r_kz));
                mul_const = HASH_MUL_Z;
            end
            default: begin
                mul_coord = 32'($signed(r_kx));
                mul_const = HASH_MUL_X;
            end
        endcase
    end

    // restoring modulo, one dividend bit a step
    always_comb begin
        div_shift = {r_rem, r_acc[31]};
        if (div_shift >= {1'b0, r_size}) begin
            n_rem = SW'(div_shift - {1'b0, r_size});
        end else begin
            n_rem = SW'(div_shift);
        end
    end

    // next probe slot, wrapping at the size in use
    always_comb begin
        cell_inc = {1'b0, r_cell} + (AW + 1)'(1);
        if (cell_inc >= (AW + 1)'(r_size)) begin
            n_cell_adv = '0;
        end else begin
            n_cell_adv = cell_inc[AW-1:0];
        end
    end

    // slot word: valid, x, y, z, handle
    assign rd_valid  = rdata[RW-1];
    assign rd_kx     = rdata[RW-2 -: CB];
    assign rd_ky     = rdata[RW-2-CB -: CB];
    assign rd_kz     = rdata[RW-2-2*CB -: CB];
    assign rd_handle = rdata[HB-1:0];
    assign key_eq    = (rd_kx == r_kx) && (rd_ky == r_ky) && (rd_kz == r_kz);

    assign ram_we    = i_cmd.clr_step || (i_cmd.prb_chk && !rd_valid && r_op);
    assign ram_wdata = i_cmd.clr_step ? '0 : {1'b1, r_kx, r_ky, r_kz, r_handle};

    chtlp_ram #(
        .WIDTH(RW),
        .DEPTH(CAPACITY)
    ) u_slots (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_cell),
        .i_wdata(ram_wdata),
        .i_re   (i_cmd.prb_rd),
        .i_raddr(r_cell),
        .o_rdata(rdata)
    );

    always_comb begin
        priority if (!rd_valid) begin
            n_res_status = r_op ? ST_INSERTED : ST_NOT_FOUND;
        end else if (key_eq) begin
            n_res_status = r_op ? ST_PRESENT : ST_FOUND;
        end else begin
            n_res_status = r_op ? ST_FULL : ST_NOT_FOUND;
        end
    end

    assign o_sts.empty    = !rd_valid;
    assign o_sts.match    = rd_valid && key_eq;
    assign o_sts.last     = (r_n + SW'(1)) == r_size;
    assign o_sts.clr_last = r_cell == AW'(CAPACITY - 1);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= TS_RESET;
            r_cell       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_table_size <= i_cfg_table_size;
            end
            priority if (i_cmd.clr_step) begin
                r_cell <= r_cell + AW'(1);
            end else if (i_cmd.home_load) begin
                r_cell <= AW'(r_rem);
            end else if (i_cmd.prb_adv) begin
                r_cell <= n_cell_adv;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op     <= i_opcode;
            r_kx     <= i_key_x;
            r_ky     <= i_key_y;
            r_kz     <= i_key_z;
            r_handle <= i_entry_handle;
            r_size   <= used_size;
            r_rem    <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_coord * mul_const;
        end
        priority if (i_cmd.start) begin
            r_acc <= '0;
        end else if (i_cmd.acc_en) begin
            r_acc <= r_acc + r_prod;
        end else if (i_cmd.div_step) begin
            r_acc <= {r_acc[30:0], 1'b0};
        end
        if (i_cmd.home_load) begin
            r_home <= AW'(r_rem);
            r_n    <= '0;
        end else if (i_cmd.prb_adv) begin
            r_n <= r_n + SW'(1);
        end
        if (i_cmd.prb_chk) begin
            r_res_status <= n_res_status;
            r_res_handle <= (rd_valid && key_eq) ? FH_W'(rd_handle) : '0;
            r_res_slot   <= (!rd_valid || key_eq) ? SLOT_W'(r_cell) : SLOT_W'(r_home);
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_handle <= r_res_handle;
            r_out_slot   <= r_res_slot;
        end
    end

    assign o_status       = r_out_status;
    assign o_found_handle = r_out_handle;
    assign o_slot_index   = r_out_slot;

`ifndef SYNTHESIS
    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.prb_chk |-> (r_n < r_size) && ((AW + 1)'(r_cell) < (AW + 1)'(r_size)))
        else $error("probe outside the table in use");

    a_result_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> (o_status <= ST_FULL))
        else $error("result status code out of range");
`endif

endmodule

/* hdl/chtlp_ctrl.sv */
// controller: clearing pass, hash, modulo and probe sequencing
module chtlp_ctrl
    import chtlp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_HASH   = 8'b0000_0100,
        S_DIV    = 8'b0000_1000,
        S_HOME   = 8'b0001_0000,
        S_PRB_RD = 8'b0010_0000,
        S_PRB_CK = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             out_free;
    logic             accept;

    assign out_free = !r_out_valid || !i_out_stall;
    assign accept   = (r_state == S_IDLE) && i_in_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_cnt       = '0;
                    n_state     = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.mul_en  = r_cnt < CNT_W'(MUL_TERMS);
                o_cmd.mul_sel = t_mul_sel'(r_cnt[1:0]);
                o_cmd.acc_en  = r_cnt != '0;
                n_cnt         = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MUL_TERMS)) begin
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_HOME;
                end
            end
            S_HOME: begin
                o_cmd.home_load = 1'b1;
                n_state         = S_PRB_RD;
            end
            S_PRB_RD: begin
                o_cmd.prb_rd = 1'b1;
                n_state      = S_PRB_CK;
            end
            S_PRB_CK: begin
                o_cmd.prb_chk = 1'b1;
                if (i_sts.empty || i_sts.match || i_sts.last) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.prb_adv = 1'b1;
                    n_state       = S_PRB_RD;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        priority if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("new transfer taken while an item is in flight");

    a_result_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && out_free |=> r_out_valid && (r_state == S_IDLE))
        else $error("finished result not presented");
`endif

endmodule

/* hdl/coord_hash_table_linear_probe.sv */
// top level of the coordinate hash table with linear probing
//
// usage
// - input channel (i_in_valid / o_in_stall) carries one lookup or insert per
//   transfer: opcode, the signed x/y/z key and, for inserts, the entry handle
// - output channel (o_out_valid / i_out_stall) returns exactly one result per
//   input transfer: status, found handle and the slot where the probe ended
// - config channel (i_cfg_valid / o_cfg_ready) writes table_size; ready is
//   always high, writes belong only in idle periods
// - after reset the slot store is swept clear one slot per cycle, all CAPACITY
//   slots (1024 by default), with the input stalled throughout; table_size
//   returns to 1024
// - sequence per item: accept, hash (shared multiplier, accumulate), restoring
//   modulo over the 32-bit hash, home load, a ram read and a check per probe,
//   and the output load
// - the modulo unit and the single ram read port set the pace; one item
//   is in flight at a time
// - the result sits in an output register, so the next item is accepted while
//   a stalled result waits; the new item then holds in its final state until
//   the register frees up
//
module coord_hash_table_linear_probe
    import chtlp_pkg::*;
#(
    parameter int CAPACITY    = 1024,
    parameter int COORD_BITS  = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // config write
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [TS_W-1:0]        i_cfg_table_size,
    // input transfer
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_opcode,
    input  logic [COORD_BITS-1:0]  i_key_x,
    input  logic [COORD_BITS-1:0]  i_key_y,
    input  logic [COORD_BITS-1:0]  i_key_z,
    input  logic [HANDLE_BITS-1:0] i_entry_handle,
    // result transfer
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [STATUS_W-1:0]    o_status,
    output logic [FH_W-1:0]        o_found_handle,
    output logic [SLOT_W-1:0]      o_slot_index
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // config is always taken
    assign o_cfg_ready = 1'b1;

    chtlp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_cmd      (dp_cmd),
        .i_sts      (dp_sts)
    );

    chtlp_dpath #(
        .CAPACITY   (CAPACITY),
        .COORD_BITS (COORD_BITS),
        .HANDLE_BITS(HANDLE_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_sts           (dp_sts),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_table_size(i_cfg_table_size),
        .i_opcode        (i_opcode),
        .i_key_x         (i_key_x),
        .i_key_y         (i_key_y),
        .i_key_z         (i_key_z),
        .i_entry_handle  (i_entry_handle),
        .o_status        (o_status),
        .o_found_handle  (o_found_handle),
        .o_slot_index    (o_slot_index)
    );

endmodule

/* tb/chtlp_checker.sv */
// checker for the coordinate hash table: watches all channels, predicts and compares results
module chtlp_checker
    import chtlp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [TS_W-1:0]     i_cfg_table_size,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic                i_opcode,
    input  logic [15:0]         i_key_x,
    input  logic [15:0]         i_key_y,
    input  logic [15:0]         i_key_z,
    input  logic [15:0]         i_entry_handle,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [STATUS_W-1:0] i_status,
    input  logic [FH_W-1:0]     i_found_handle,
    input  logic [SLOT_W-1:0]   i_slot_index,
    output int                  o_error_count,
    output int                  o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = 1024;

    typedef struct packed {
        t_status             status;
        logic [FH_W-1:0]     handle;
        logic [SLOT_W-1:0]   slot;
    } t_probe_result;

    // shadow of the slot store and the size register
    logic [TS_W-1:0] size_shadow;
    logic            slot_used   [CAPACITY];
    logic [47:0]     slot_coords [CAPACITY];
    logic [15:0]     slot_handle [CAPACITY];

    t_probe_result pending_results[$];
    int            mismatch_count = 0;
    int            waiting_count  = 0;

    assign o_error_count = mismatch_count;
    assign o_outstanding = waiting_count;

    // walk the table from the home slot, updating the shadow on insert
    function automatic t_probe_result probe_table(input logic is_insert,
                                                  input logic [15:0] kx,
                                                  input logic [15:0] ky,
                                                  input logic [15:0] kz,
                                                  input logic [15:0] handle);
        logic [31:0]   hash;
        logic [31:0]   span;
        logic [31:0]   home;
        logic [47:0]   coords;
        int unsigned   pos;
        int unsigned   n;
        t_probe_result res;
        span   = (size_shadow == '0) ? 32'd1 :
                 (size_shadow > CAPACITY) ? 32'(CAPACITY) : 32'(size_shadow);
        hash   = {{16{kx[15]}}, kx} * HASH_MUL_X + {{16{ky[15]}}, ky} * HASH_MUL_Y
               + {{16{kz[15]}}, kz} * HASH_MUL_Z;
        home   = hash % span;
        coords = {kx, ky, kz};
        res.status = is_insert ? ST_FULL : ST_NOT_FOUND;
        res.handle = '0;
        res.slot   = home[SLOT_W-1:0];
        pos        = home;
        for (n = 0; n < span; n++) begin
            if (!slot_used[pos]) begin
                if (is_insert) begin
                    slot_used[pos]   = 1'b1;
                    slot_coords[pos] = coords;
                    slot_handle[pos] = handle;
                    res.status       = ST_INSERTED;
                end else begin
                    res.status = ST_NOT_FOUND;
                end
                res.slot = pos[SLOT_W-1:0];
                break;
            end
            if (slot_coords[pos] == coords) begin
                res.status = is_insert ? ST_PRESENT : ST_FOUND;
                res.handle = slot_handle[pos];
                res.slot   = pos[SLOT_W-1:0];
                break;
            end
            pos = (pos + 1 >= span) ? 0 : pos + 1;
        end
        return res;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_probe_result want;
        if (!i_rst_n) begin
            size_shadow = TS_RESET;
            for (int i = 0; i < CAPACITY; i++) slot_used[i] = 1'b0;
            pending_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) size_shadow = i_cfg_table_size;
            if (i_in_valid && !i_in_stall)
                pending_results.push_back(probe_table(i_opcode, i_key_x, i_key_y,
                                                      i_key_z, i_entry_handle));
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, got status %0d",
                             $time, i_status);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(i_status));
                    check_field("found_handle", 32'(want.handle), 32'(i_found_handle));
                    check_field("slot_index", 32'(want.slot), 32'(i_slot_index));
                end
            end
        end
        waiting_count = pending_results.size();
    end

endmodule

/* tb/tb_coord_hash_table_linear_probe.sv */
// testbench top for the coordinate hash table: stimulus, flow control and verdict
module tb_coord_hash_table_linear_probe;
    timeunit 1ns;
    timeprecision 1ps;

    import chtlp_pkg::*;

    localparam int HALF_PERIOD   = 1;
    localparam int RESET_CYCLES  = 8;
    localparam int PHASE_COUNT   = 12;
    localparam int PHASE_ITEMS   = 125;
    localparam int POOL_CAP      = 48;
    localparam int LONG_HOLD     = 300;
    localparam int HOLD_PHASE    = 5;
    localparam int SETTLE_CYCLES = 64;
    // worst case is a full sweep of 1024 slots per item plus the longest gaps,
    // for every item, taken several times over
    localparam int TIMEOUT_NS    = 40_000_000;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
    } t_coord;

    // corner keys for the directed part
    localparam t_coord KEY_ZERO  = {16'h0000, 16'h0000, 16'h0000};
    localparam t_coord KEY_MIN   = {16'h8000, 16'h8000, 16'h8000};
    localparam t_coord KEY_MAX   = {16'h7FFF, 16'h7FFF, 16'h7FFF};
    localparam t_coord KEY_MIXED = {16'h8000, 16'h7FFF, 16'h0001};
    localparam t_coord KEY_NEG   = {16'hFFFF, 16'hFFFF, 16'hFFFF};

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [TS_W-1:0]     i_cfg_table_size;
    logic                i_in_valid;
    logic                o_in_stall;
    logic                i_opcode;
    logic [15:0]         i_key_x;
    logic [15:0]         i_key_y;
    logic [15:0]         i_key_z;
    logic [15:0]         i_entry_handle;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [STATUS_W-1:0] o_status;
    logic [FH_W-1:0]     o_found_handle;
    logic [SLOT_W-1:0]   o_slot_index;

    int error_count;
    int outstanding;

    // flow-control knobs shared between the stimulus and the result sink
    logic quiet         = 1'b0;
    logic hold_request  = 1'b0;
    logic hold_served   = 1'b0;

    // keys of the current phase, and every key ever offered for insert
    t_coord phase_keys[$];
    t_coord seen_keys[$];

    always #HALF_PERIOD i_clk = ~i_clk;

    coord_hash_table_linear_probe DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_table_size (i_cfg_table_size),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_key_x          (i_key_x),
        .i_key_y          (i_key_y),
        .i_key_z          (i_key_z),
        .i_entry_handle   (i_entry_handle),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_found_handle   (o_found_handle),
        .o_slot_index     (o_slot_index)
    );

    chtlp_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_table_size (i_cfg_table_size),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_key_x          (i_key_x),
        .i_key_y          (i_key_y),
        .i_key_z          (i_key_z),
        .i_entry_handle   (i_entry_handle),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_status         (o_status),
        .i_found_handle   (o_found_handle),
        .i_slot_index     (o_slot_index),
        .o_error_count    (error_count),
        .o_outstanding    (outstanding)
    );

    // idle length for either side: mostly none, often a few cycles, now and then
    // a long stretch; nothing at all in quiet phases
    function automatic int unsigned idle_span();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (quiet || pick < 55) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(12, 70);
    endfunction

    // coordinate with a bias towards the two's complement corners
    function automatic logic [15:0] random_coord();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // one input transfer; entered and left on a falling edge
    task automatic issue_request(input logic op, input t_coord key, input logic [15:0] handle);
        int unsigned gap;
        gap = idle_span();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_key_x        <= key.x;
        i_key_y        <= key.y;
        i_key_z        <= key.z;
        i_entry_handle <= handle;
        // payload holds until the edge that takes the transfer
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // size register write; only issued once the block has gone idle
    task automatic write_table_size(input logic [TS_W-1:0] value);
        i_cfg_valid      <= 1'b1;
        i_cfg_table_size <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // sender pause until every outstanding result is back, then let the block settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // result sink: random back-pressure, plus one long hold-off so the output
    // register and the in-flight item both fill and the input stalls
    initial begin : result_sink
        int unsigned span;
        i_out_stall = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_request && !hold_served) begin
                hold_served = 1'b1;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else begin
                span = idle_span();
                i_out_stall <= (span != 0);
                repeat ((span == 0) ? 1 : span) @(negedge i_clk);
            end
        end
    end

    // watchdog
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        int unsigned     pick;
        int unsigned     span_used;
        int unsigned     pool_len;
        int              phase;
        logic [TS_W-1:0] size_word;
        t_coord          key;
        logic            op;

        // every input known from time zero
        i_rst_n          = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_table_size = TS_RESET;
        i_in_valid       = 1'b0;
        i_opcode         = OP_LOOKUP;
        i_key_x          = '0;
        i_key_y          = '0;
        i_key_z          = '0;
        i_entry_handle   = '0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, full table size after reset; the first transfer simply waits
        // out the clearing sweep behind the input stall
        issue_request(OP_LOOKUP, KEY_ZERO, 16'h0000);   // empty table, zero hash
        issue_request(OP_INSERT, KEY_ZERO, 16'hFFFF);
        issue_request(OP_INSERT, KEY_ZERO, 16'h1234);   // already present, handle kept
        issue_request(OP_LOOKUP, KEY_ZERO, 16'h0000);
        issue_request(OP_INSERT, KEY_MIN, 16'h0000);    // collides with the zero key
        issue_request(OP_INSERT, KEY_MAX, 16'hA5A5);
        issue_request(OP_LOOKUP, KEY_MIN, 16'hFFFF);
        issue_request(OP_LOOKUP, KEY_MAX, 16'h0000);
        issue_request(OP_INSERT, KEY_MIXED, 16'h5A5A);
        issue_request(OP_LOOKUP, KEY_MIXED, 16'h0000);
        issue_request(OP_LOOKUP, KEY_NEG, 16'hFFFF);

        // size zero acts as one slot: a table that is already full
        drain_results();
        write_table_size(11'd0);
        issue_request(OP_LOOKUP, KEY_ZERO, 16'h0000);
        issue_request(OP_INSERT, KEY_MAX, 16'h1111);    // full, home slot reported
        issue_request(OP_LOOKUP, KEY_MAX, 16'h0000);    // not found on a full table
        issue_request(OP_INSERT, KEY_ZERO, 16'h2222);

        // two slots: probing wraps at the size in use
        drain_results();
        write_table_size(11'd2);
        issue_request(OP_INSERT, KEY_MIXED, 16'h3333);
        issue_request(OP_LOOKUP, KEY_NEG, 16'h0000);

        // above capacity is clamped; old entries reachable again
        drain_results();
        write_table_size(11'h7FF);
        issue_request(OP_LOOKUP, KEY_MAX, 16'h0000);
        issue_request(OP_LOOKUP, KEY_MIXED, 16'h0000);
        issue_request(OP_INSERT, KEY_NEG, 16'h8001);

        seen_keys = '{KEY_ZERO, KEY_MIN, KEY_MAX, KEY_MIXED, KEY_NEG};

        // random phases, each at its own table size; slots survive resizing so
        // keys from earlier phases turn up again at new home slots
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0:       size_word = 11'h7FF;
                1:       size_word = 11'd0;
                2:       size_word = 11'd2;
                3:       size_word = 11'($urandom_range(3, 24));
                4:       size_word = 11'($urandom_range(100, 1024));
                5:       size_word = TS_RESET;
                6:       size_word = 11'd1;
                7:       size_word = 11'($urandom_range(25, 300));
                8:       size_word = 11'($urandom);
                9:       size_word = 11'd1023;
                10:      size_word = 11'($urandom_range(2, 16));
                default: size_word = TS_RESET;
            endcase

            drain_results();
            write_table_size(size_word);
            quiet = (phase % 4 == 3);
            if (phase == HOLD_PHASE) hold_request = 1'b1;

            // a pool a little larger than the table in small sizes, so it fills
            // and overflows; capped in large sizes so lookups mostly hit
            span_used = (size_word == 0) ? 1 : (size_word > 1024) ? 1024 : size_word;
            pool_len  = span_used + $urandom_range(1, 4);
            if (pool_len > POOL_CAP) pool_len = POOL_CAP;
            phase_keys.delete();
            repeat (pool_len)
                phase_keys.push_back({random_coord(), random_coord(), random_coord()});

            repeat (PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    key = phase_keys[$urandom_range(0, phase_keys.size() - 1)];
                else if (pick < 80)
                    key = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
                else
                    key = {random_coord(), random_coord(), random_coord()};
                op = $urandom_range(0, 1) ? OP_INSERT : OP_LOOKUP;
                if (op == OP_INSERT) seen_keys.push_back(key);
                issue_request(op, key, 16'($urandom));
            end
        end

        drain_results();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
